@@ sv/skvt_pkg.sv @@
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants for the small key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int CAPACITY  = 32;
   localparam int KEY_W     = 32;
   localparam int VAL_W     = 32;
   localparam int POS_W     = 5;
   localparam int ENTRIES_W = 6;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int CMP_W     = POS_W + IDX_W;

   typedef enum logic [2:0] {
      OP_PUT             = 3'd0,
      OP_FETCH_OR_CREATE = 3'd1,
      OP_SET             = 3'd2,
      OP_GET             = 3'd3,
      OP_DELETE          = 3'd4,
      OP_CLEAR           = 3'd5,
      OP_READ_AT         = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ABSENT = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic             capture;    // latch compare results
      logic [KEY_W-1:0] cmp_key;
      logic [POS_W-1:0] cmp_pos;
      logic [CNT_W-1:0] count;
      logic             write_hit;  // overwrite value in the matching cell
      logic             append;     // write key/value in the cell at index count
      logic             shift;      // cells at or above the match take their neighbor
      logic [KEY_W-1:0] wr_key;
      logic [VAL_W-1:0] wr_value;
   } cell_ctl_type;

endpackage

@@ sv/skvt_cell.sv @@
// ----------------------------------------------------------------------------
// skvt_cell
// One table slot: holds a key/value pair, matches key and position, and
// takes its upper neighbor's contents when an entry below it is deleted.
// ----------------------------------------------------------------------------
module skvt_cell
   import skvt_pkg::*;
(
   input  logic             clock,
   input  logic [IDX_W-1:0] idx,
   input  cell_ctl_type     ctl,
   input  logic [KEY_W-1:0] next_key,
   input  logic [VAL_W-1:0] next_value,
   input  logic             ge_in,
   output logic             ge_out,
   output logic             hit,
   output logic             pos_hit,
   output logic [KEY_W-1:0] key,
   output logic [VAL_W-1:0] value
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             hit_ff, hit_in;
   logic             pos_hit_ff, pos_hit_in;
   logic             valid;

   assign valid  = CNT_W'(idx) < ctl.count;
   // at-or-above-match flag ripples up the row
   assign ge_out = ge_in | hit_ff;

   always_comb begin
      key_in     = key_ff;
      value_in   = value_ff;
      hit_in     = hit_ff;
      pos_hit_in = pos_hit_ff;
      if (ctl.capture) begin
         hit_in     = valid && (ctl.cmp_key == key_ff);
         pos_hit_in = valid && (CMP_W'(ctl.cmp_pos) == CMP_W'(idx));
      end
      if (ctl.write_hit && hit_ff) begin
         value_in = ctl.wr_value;
      end
      if (ctl.append && (CNT_W'(idx) == ctl.count)) begin
         key_in   = ctl.wr_key;
         value_in = ctl.wr_value;
      end
      if (ctl.shift && ge_out) begin
         key_in   = next_key;
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      value_ff   <= value_in;
      hit_ff     <= hit_in;
      pos_hit_ff <= pos_hit_in;
   end

   assign hit     = hit_ff;
   assign pos_hit = pos_hit_ff;
   assign key     = key_ff;
   assign value   = value_ff;

endmodule

@@ sv/small_key_value_table.sv @@
// ----------------------------------------------------------------------------
// small_key_value_table
// Insertion-ordered key/value table built from a row of slot cells.
// ----------------------------------------------------------------------------
// Each transaction passes from idle to the update state. On acceptance every
// cell compares the key and position against its own entry at once; in the
// update state the match is selected, the table is updated (value write,
// append at the tail, or a one-place shift down the row on delete) and the
// response register is loaded. A new request is taken only after the previous
// one leaves the update state, which it does as long as the response register
// is free or being drained; a stalled response holds it. Keys are unique
// among valid entries, so at most one cell matches. Reset empties the table.
module small_key_value_table
   import skvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_op,
   input  logic [KEY_W-1:0]     req_key,
   input  logic [VAL_W-1:0]     req_value,
   input  logic [POS_W-1:0]     req_position,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [KEY_W-1:0]     rsp_key_out,
   output logic [VAL_W-1:0]     rsp_value_out,
   output logic [ENTRIES_W-1:0] rsp_entries,
   output logic [1:0]           rsp_status
);

   typedef enum logic {S_IDLE, S_UPDATE} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   op_type           op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] value_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [ENTRIES_W-1:0] rsp_entries_ff, rsp_entries_in;
   status_type           rsp_status_ff, rsp_status_in;

   cell_ctl_type     ctl;
   logic             accept, commit;
   logic             hit_any, pos_any, full;
   logic [KEY_W-1:0] pos_key;
   logic [VAL_W-1:0] sel_value, pos_value;

   logic [CAPACITY-1:0] hit_v, pos_v;
   logic [CAPACITY:0]   ge_v;
   logic [KEY_W-1:0]    key_v   [CAPACITY+1];
   logic [VAL_W-1:0]    value_v [CAPACITY+1];

   assign accept = req_valid && !req_stall;
   assign commit = (state_ff == S_UPDATE) && !(rsp_valid_ff && rsp_stall);
   assign full   = count_ff == CNT_W'(CAPACITY);

   // the top cell shifts in don't-care contents
   assign key_v[CAPACITY]   = '0;
   assign value_v[CAPACITY] = '0;
   assign ge_v[0]           = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      skvt_cell u_cell (
         .clock      (clock),
         .idx        (IDX_W'(i)),
         .ctl        (ctl),
         .next_key   (key_v[i+1]),
         .next_value (value_v[i+1]),
         .ge_in      (ge_v[i]),
         .ge_out     (ge_v[i+1]),
         .hit        (hit_v[i]),
         .pos_hit    (pos_v[i]),
         .key        (key_v[i]),
         .value      (value_v[i])
      );
   end

   // one-hot select of the matching cell
   always_comb begin
      sel_value = '0;
      pos_key   = '0;
      pos_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_value = sel_value | (value_v[i] & {VAL_W{hit_v[i]}});
         pos_key   = pos_key   | (key_v[i]   & {KEY_W{pos_v[i]}});
         pos_value = pos_value | (value_v[i] & {VAL_W{pos_v[i]}});
      end
   end

   assign hit_any = |hit_v;
   assign pos_any = |pos_v;

   always_comb begin
      ctl.capture   = accept;
      ctl.cmp_key   = req_key;
      ctl.cmp_pos   = req_position;
      ctl.count     = count_ff;
      ctl.wr_key    = key_ff;
      ctl.wr_value  = (op_ff == OP_FETCH_OR_CREATE) ? '0 : value_ff;
      ctl.write_hit = commit && hit_any && ((op_ff == OP_PUT) || (op_ff == OP_SET));
      ctl.append    = commit && !hit_any && !full
                      && ((op_ff == OP_PUT) || (op_ff == OP_FETCH_OR_CREATE));
      ctl.shift     = commit && hit_any && (op_ff == OP_DELETE);
   end

   // response and count for the transaction in the update cycle
   always_comb begin
      count_in      = count_ff;
      rsp_found_in  = 1'b0;
      rsp_key_in    = '0;
      rsp_value_in  = '0;
      rsp_status_in = ST_OK;
      unique case (op_ff)
         OP_PUT, OP_FETCH_OR_CREATE: begin
            rsp_key_in   = key_ff;
            rsp_found_in = hit_any;
            if (hit_any) begin
               rsp_value_in = (op_ff == OP_PUT) ? value_ff : sel_value;
            end else if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_value_in = ctl.wr_value;
               count_in     = count_ff + 1'b1;
            end
         end
         OP_SET, OP_GET: begin
            rsp_key_in   = key_ff;
            rsp_found_in = hit_any;
            if (hit_any) begin
               rsp_value_in = (op_ff == OP_SET) ? value_ff : sel_value;
            end else begin
               rsp_status_in = ST_ABSENT;
            end
         end
         OP_DELETE: begin
            rsp_key_in   = key_ff;
            rsp_found_in = hit_any;
            if (hit_any) begin
               count_in = count_ff - 1'b1;
            end else begin
               rsp_status_in = ST_ABSENT;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_READ_AT: begin
            rsp_found_in = pos_any;
            if (pos_any) begin
               rsp_key_in   = pos_key;
               rsp_value_in = pos_value;
            end else begin
               rsp_status_in = ST_ABSENT;
            end
         end
         default: begin
         end
      endcase
      rsp_entries_in = ENTRIES_W'(count_in);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= op_type'(req_op);
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (commit) begin
         rsp_found_ff   <= rsp_found_in;
         rsp_key_ff     <= rsp_key_in;
         rsp_value_ff   <= rsp_value_in;
         rsp_entries_ff <= rsp_entries_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign req_stall     = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_entries   = rsp_entries_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

@@ sv/skvt_checker.sv @@
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks for the small key/value table, bound to the top level.
// ----------------------------------------------------------------------------
module skvt_checker
   import skvt_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_found,
   input logic [VAL_W-1:0]     rsp_value_out,
   input logic [ENTRIES_W-1:0] rsp_entries,
   input logic [1:0]           rsp_status
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // the table is busy for the cycle after a transaction is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   // a full refusal only happens with every slot in use
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL)
      |-> (rsp_entries == ENTRIES_W'(CAPACITY)) && !rsp_found && (rsp_value_out == '0))
      else $error("full status with free slots");

   // a hit always reports ok
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK)
      else $error("found with error status");

endmodule

bind small_key_value_table skvt_checker u_skvt_checker (.*);
